// ===== rtl/tchp_pkg.sv =====
// Shared types, codes and character helpers for the trace context header parser.
package tchp_pkg;

  typedef enum logic [1:0] {
    PH_VERSION = 2'd0,
    PH_TRACE   = 2'd1,
    PH_PARENT  = 2'd2,
    PH_FLAGS   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MALFORMED   = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_BAD_TRACE   = 3'd3,
    ST_BAD_PARENT  = 3'd4,
    ST_BAD_FLAGS   = 3'd5
  } status_e;

  localparam int unsigned PosW = 7;

  localparam logic [7:0]      CharDash     = 8'h2d;
  localparam logic [15:0]     VersionFf    = 16'h6666;
  localparam logic [15:0]     Version00    = 16'h3030;
  localparam logic [PosW-1:0] VersionLimit = 7'd2;
  localparam logic [PosW-1:0] TraceLimit   = 7'd35;
  localparam logic [PosW-1:0] ParentLimit  = 7'd52;
  // A header is long enough when at least 55 characters arrived, i.e. the
  // last one sits at position 54 or later.
  localparam logic [PosW-1:0] LastPosMin   = 7'd54;
  localparam logic [PosW-1:0] PosMax       = 7'd127;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [7:0]      char_code;
    hex_t            hex;
    logic            is_dash;
    logic            is_last;
    logic [PosW-1:0] pos;
  } item_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== rtl/tchp_front.sv =====
// Front end: takes header characters, numbers them and classifies each one.
module tchp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    char_code_i,
  input  logic          is_last_i,
  output logic          push_o,
  input  logic          queue_ready_i,
  output tchp_pkg::item_t item_o
);

  logic [tchp_pkg::PosW-1:0] pos_q, pos_d;

  assign in_ready_o = queue_ready_i;
  assign push_o     = in_valid_i && queue_ready_i;

  always_comb begin
    item_o.char_code = char_code_i;
    item_o.hex       = tchp_pkg::hex_decode(char_code_i);
    item_o.is_dash   = (char_code_i == tchp_pkg::CharDash);
    item_o.is_last   = is_last_i;
    item_o.pos       = pos_q;
  end

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (is_last_i) begin
        pos_d = '0;
      end else if (pos_q != tchp_pkg::PosMax) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== rtl/tchp_queue.sv =====
// Two-entry queue of classified characters between the front and back ends.
module tchp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            ready_o,
  input  tchp_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            pop_i,
  output tchp_pkg::item_t item_o
);

  tchp_pkg::item_t mem_q [2];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/tchp_back.sv =====
// Back end: walks the header fields, checks them and registers the result.
module tchp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            pop_o,
  input  tchp_pkg::item_t item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      status_o,
  output logic [63:0]     trace_id_hi_o,
  output logic [63:0]     trace_id_low_o,
  output logic [63:0]     parent_span_o,
  output logic            sampled_o
);

  tchp_pkg::phase_e          phase_q, phase_d, f_phase;
  tchp_pkg::status_e         ferr_q, ferr_d, f_ferr, end_status;
  logic [tchp_pkg::PosW-1:0] seg_q, seg_d, f_seg, pos_next;
  logic [15:0]               ver_q, ver_d, f_ver;
  logic [1:0]                verlen_q, verlen_d, f_verlen;
  logic [63:0]               th_q, th_d, f_th;
  logic [63:0]               tl_q, tl_d, f_tl;
  logic                      tbad_q, tbad_d, f_tbad;
  logic [63:0]               pacc_q, pacc_d, f_pacc;
  logic                      pbad_q, pbad_d, f_pbad;
  logic [15:0]               flag_q, flag_d, f_flag;
  logic [1:0]                tcnt_q, tcnt_d, f_tcnt;
  logic                      tdash_q, tdash_d, f_tdash;
  tchp_pkg::hex_t            flag_hi, flag_lo;

  logic                      out_valid_q, out_valid_d;
  logic [2:0]                status_q;
  logic [63:0]               th_out_q, tl_out_q, pacc_out_q;
  logic                      sampled_q;
  logic                      finish;

  assign pop_o    = item_valid_i && (!item_i.is_last || !out_valid_q || out_ready_i);
  assign finish   = pop_o && item_i.is_last;
  assign pos_next = item_i.pos + 1'b1;

  // Field walk for one character, as if it is accepted.
  always_comb begin
    f_ferr   = ferr_q;
    f_seg    = seg_q;
    f_ver    = ver_q;
    f_verlen = verlen_q;
    f_th     = th_q;
    f_tl     = tl_q;
    f_tbad   = tbad_q;
    f_pacc   = pacc_q;
    f_pbad   = pbad_q;
    f_flag   = flag_q;
    f_tcnt   = tcnt_q;
    f_tdash  = tdash_q;
    if (ferr_q == tchp_pkg::ST_OK) begin
      unique case (phase_q)
        tchp_pkg::PH_VERSION: begin
          if (item_i.pos > tchp_pkg::VersionLimit) begin
            f_ferr = tchp_pkg::ST_MALFORMED;
          end else if (item_i.is_dash) begin
            if (verlen_q == 2'd2 && ver_q == tchp_pkg::VersionFf) begin
              f_ferr = tchp_pkg::ST_BAD_VERSION;
            end else begin
              f_seg = pos_next;
            end
          end else if (!item_i.hex.ok) begin
            f_ferr = tchp_pkg::ST_BAD_VERSION;
          end else begin
            f_ver = {ver_q[7:0], item_i.char_code};
            if (verlen_q != 2'd3) begin
              f_verlen = verlen_q + 2'd1;
            end
          end
        end
        tchp_pkg::PH_TRACE: begin
          if (item_i.pos > tchp_pkg::TraceLimit) begin
            f_ferr = tchp_pkg::ST_MALFORMED;
          end else if (item_i.is_dash) begin
            if (tbad_q || seg_q == item_i.pos || (th_q == '0 && tl_q == '0)) begin
              f_ferr = tchp_pkg::ST_BAD_TRACE;
            end else begin
              f_seg = pos_next;
            end
          end else if (!item_i.hex.ok || th_q[63:60] != 4'd0) begin
            f_tbad = 1'b1;
          end else begin
            f_th = {th_q[59:0], tl_q[63:60]};
            f_tl = {tl_q[59:0], item_i.hex.val};
          end
        end
        tchp_pkg::PH_PARENT: begin
          if (item_i.pos > tchp_pkg::ParentLimit) begin
            f_ferr = tchp_pkg::ST_MALFORMED;
          end else if (item_i.is_dash) begin
            if (pbad_q || seg_q == item_i.pos || pacc_q == '0) begin
              f_ferr = tchp_pkg::ST_BAD_PARENT;
            end else begin
              f_seg  = pos_next;
              f_tcnt = 2'd0;
            end
          end else if (!item_i.hex.ok || pacc_q[63:60] != 4'd0) begin
            f_pbad = 1'b1;
          end else begin
            f_pacc = {pacc_q[59:0], item_i.hex.val};
          end
        end
        tchp_pkg::PH_FLAGS: begin
          if (tcnt_q < 2'd2) begin
            f_flag = {flag_q[7:0], item_i.char_code};
          end else if (tcnt_q == 2'd2) begin
            f_tdash = item_i.is_dash;
          end
          if (tcnt_q != 2'd3) begin
            f_tcnt = tcnt_q + 2'd1;
          end
        end
        default: begin
          f_ferr = ferr_q;
        end
      endcase
    end
  end

  // Next field.
  always_comb begin
    f_phase = phase_q;
    if (ferr_q == tchp_pkg::ST_OK && item_i.is_dash) begin
      unique case (phase_q)
        tchp_pkg::PH_VERSION: begin
          if (item_i.pos <= tchp_pkg::VersionLimit &&
              !(verlen_q == 2'd2 && ver_q == tchp_pkg::VersionFf)) begin
            f_phase = tchp_pkg::PH_TRACE;
          end
        end
        tchp_pkg::PH_TRACE: begin
          if (item_i.pos <= tchp_pkg::TraceLimit && !tbad_q && seg_q != item_i.pos &&
              !(th_q == '0 && tl_q == '0)) begin
            f_phase = tchp_pkg::PH_PARENT;
          end
        end
        tchp_pkg::PH_PARENT: begin
          if (item_i.pos <= tchp_pkg::ParentLimit && !pbad_q && seg_q != item_i.pos &&
              pacc_q != '0) begin
            f_phase = tchp_pkg::PH_FLAGS;
          end
        end
        default: begin
          f_phase = phase_q;
        end
      endcase
    end
  end

  // Final status, from the state after the last character.
  always_comb begin
    flag_hi = tchp_pkg::hex_decode(f_flag[15:8]);
    flag_lo = tchp_pkg::hex_decode(f_flag[7:0]);
    if (item_i.pos < tchp_pkg::LastPosMin) begin
      end_status = tchp_pkg::ST_MALFORMED;
    end else if (f_ferr != tchp_pkg::ST_OK) begin
      end_status = f_ferr;
    end else if (f_phase != tchp_pkg::PH_FLAGS) begin
      end_status = tchp_pkg::ST_MALFORMED;
    end else if (f_tcnt < 2'd2) begin
      end_status = tchp_pkg::ST_MALFORMED;
    end else if (f_tcnt == 2'd3 &&
                 ((f_verlen == 2'd2 && f_ver == tchp_pkg::Version00) || !f_tdash)) begin
      end_status = tchp_pkg::ST_MALFORMED;
    end else if (!flag_hi.ok || !flag_lo.ok) begin
      end_status = tchp_pkg::ST_BAD_FLAGS;
    end else begin
      end_status = tchp_pkg::ST_OK;
    end
  end

  // Register update: hold when idle, clear after the last character.
  always_comb begin
    phase_d  = phase_q;
    ferr_d   = ferr_q;
    seg_d    = seg_q;
    ver_d    = ver_q;
    verlen_d = verlen_q;
    th_d     = th_q;
    tl_d     = tl_q;
    tbad_d   = tbad_q;
    pacc_d   = pacc_q;
    pbad_d   = pbad_q;
    flag_d   = flag_q;
    tcnt_d   = tcnt_q;
    tdash_d  = tdash_q;
    if (finish) begin
      phase_d  = tchp_pkg::PH_VERSION;
      ferr_d   = tchp_pkg::ST_OK;
      seg_d    = '0;
      ver_d    = '0;
      verlen_d = '0;
      th_d     = '0;
      tl_d     = '0;
      tbad_d   = 1'b0;
      pacc_d   = '0;
      pbad_d   = 1'b0;
      flag_d   = '0;
      tcnt_d   = '0;
      tdash_d  = 1'b0;
    end else if (pop_o) begin
      phase_d  = f_phase;
      ferr_d   = f_ferr;
      seg_d    = f_seg;
      ver_d    = f_ver;
      verlen_d = f_verlen;
      th_d     = f_th;
      tl_d     = f_tl;
      tbad_d   = f_tbad;
      pacc_d   = f_pacc;
      pbad_d   = f_pbad;
      flag_d   = f_flag;
      tcnt_d   = f_tcnt;
      tdash_d  = f_tdash;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tchp_pkg::PH_VERSION;
      ferr_q      <= tchp_pkg::ST_OK;
      seg_q       <= '0;
      ver_q       <= '0;
      verlen_q    <= '0;
      th_q        <= '0;
      tl_q        <= '0;
      tbad_q      <= 1'b0;
      pacc_q      <= '0;
      pbad_q      <= 1'b0;
      flag_q      <= '0;
      tcnt_q      <= '0;
      tdash_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      ferr_q      <= ferr_d;
      seg_q       <= seg_d;
      ver_q       <= ver_d;
      verlen_q    <= verlen_d;
      th_q        <= th_d;
      tl_q        <= tl_d;
      tbad_q      <= tbad_d;
      pacc_q      <= pacc_d;
      pbad_q      <= pbad_d;
      flag_q      <= flag_d;
      tcnt_q      <= tcnt_d;
      tdash_q     <= tdash_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_q <= end_status;
      if (end_status == tchp_pkg::ST_OK) begin
        th_out_q   <= f_th;
        tl_out_q   <= f_tl;
        pacc_out_q <= f_pacc;
        sampled_q  <= flag_lo.val[0];
      end else begin
        th_out_q   <= '0;
        tl_out_q   <= '0;
        pacc_out_q <= '0;
        sampled_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign trace_id_hi_o  = th_out_q;
  assign trace_id_low_o = tl_out_q;
  assign parent_span_o  = pacc_out_q;
  assign sampled_o      = sampled_q;

`ifndef ASSERT_OFF
  // A waiting result is never overwritten by the next header's end.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !finish)
    else $error("result overwritten while stalled");

  // A good result always carries a nonzero parent id and trace id.
  a_ok_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == tchp_pkg::ST_OK |->
      parent_span_o != '0 && (th_out_q != '0 || tl_out_q != '0))
    else $error("ok result with zero id");

  // After a header ends the walk starts over at the version field.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> phase_q == tchp_pkg::PH_VERSION && ferr_q == tchp_pkg::ST_OK)
    else $error("parser not cleared after last character");
`endif

endmodule

// ===== rtl/trace_context_header_parser_unit.sv =====
// Top level of the trace context header parser: front end, queue and back end.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   char_code_i, is_last_i
//   out      output     out_valid_o/out_ready_i status_o, trace_id_hi_o,
//                                               trace_id_low_o, parent_span_o, sampled_o
//
// One character is taken per cycle while the queue has room. Each character is
// registered in the two-entry queue before it reaches the back end, and the
// result is valid from the edge at which the last character leaves the queue.
// Reset empties the queue and clears the parser. A stalled result holds only
// the last character of the next header; earlier characters keep flowing until
// the queue fills.
module trace_context_header_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] trace_id_hi_o,
  output logic [63:0] trace_id_low_o,
  output logic [63:0] parent_span_o,
  output logic        sampled_o
);

  tchp_pkg::item_t front_item, back_item;
  logic            push, queue_ready, queue_valid, pop;

  tchp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .is_last_i    (is_last_i),
    .push_o       (push),
    .queue_ready_i(queue_ready),
    .item_o       (front_item)
  );

  tchp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ready_o(queue_ready),
    .item_i (front_item),
    .valid_o(queue_valid),
    .pop_i  (pop),
    .item_o (back_item)
  );

  tchp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (queue_valid),
    .pop_o         (pop),
    .item_i        (back_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .trace_id_hi_o (trace_id_hi_o),
    .trace_id_low_o(trace_id_low_o),
    .parent_span_o (parent_span_o),
    .sampled_o     (sampled_o)
  );

endmodule
